[rtl/scec_pkg.sv]
// Shared constants and entity table for the special-character entity codec.
package scec_pkg;

    localparam int NUM_ENT     = 9;   // entities known to the codec
    localparam int ENT_MAX_LEN = 6;   // longest entity text, also max results per byte
    localparam int HOLD_DEPTH  = 5;   // bytes held while an entity prefix is open

    localparam logic [7:0] CH_AMP  = "&";
    localparam logic [7:0] CH_PAD  = 8'h00;

    typedef logic [7:0] byte_t;
    typedef logic [2:0] len_t;
    typedef logic [3:0] ent_idx_t;

    // Entity text, first byte at index 0, padded with zeros.
    localparam byte_t ENT_TEXT [NUM_ENT][ENT_MAX_LEN] = '{
        '{"&", "a", "m", "p", ";", CH_PAD},
        '{"&", "l", "t", ";", CH_PAD, CH_PAD},
        '{"&", "g", "t", ";", CH_PAD, CH_PAD},
        '{"&", "#", "4", "0", ";", CH_PAD},
        '{"&", "#", "4", "1", ";", CH_PAD},
        '{"&", "#", "4", "2", ";", CH_PAD},
        '{"&", "#", "4", "3", ";", CH_PAD},
        '{"&", "#", "6", "3", ";", CH_PAD},
        '{"&", "#", "1", "2", "4", ";"}
    };

    localparam len_t ENT_LEN [NUM_ENT] = '{
        3'd5, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd6
    };

    localparam byte_t ENT_CHAR [NUM_ENT] = '{
        "&", "<", ">", "(", ")", "*", "+", "?", "|"
    };

    typedef enum logic {
        MODE_ESCAPE   = 1'b0,
        MODE_UNESCAPE = 1'b1
    } mode_t;

endpackage

[rtl/special_char_entity_codec_core.sv]
// Top level of the special-character entity codec: escape/unescape of nine entities.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+----------------------------------------------
//  s_      | in  | s_tvalid / s_tready   | s_tdata[7:0] text_byte, s_tlast message_end
//  m_      | out | m_tvalid / m_tready   | m_tdata[7:0] out_byte, m_tuser run_last,
//          |     |                       | m_tlast text_last
//  cfg_    | in  | cfg_valid / cfg_ready | cfg_data direction_mode (0 escape, 1 unescape)
//
// An input request is decoded in the cycle it is accepted and its 0..6 result bytes are
// loaded into a result shift register, which sends one byte per cycle while m_tready is
// high. The next request is taken alongside the last result of the current one, so
// plain text streams at one byte per cycle while m_tready stays high.
// Reset (aresetn low, synchronous) selects escape mode and empties both the held
// entity prefix and the result register. Stalls on m_ hold m_ payload and back up s_.
// A configuration write is always taken and drops any held partial entity.
module special_char_entity_codec_core (
    input  logic       aclk,
    input  logic       aresetn,
    // input text
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] text_byte
    input  logic       s_tlast,   // message_end
    // converted text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tuser,   // run_last
    output logic       m_tlast,   // text_last
    // mode register write
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data   // direction_mode
);

    localparam int NE = scec_pkg::NUM_ENT;
    localparam int ML = scec_pkg::ENT_MAX_LEN;
    localparam int HD = scec_pkg::HOLD_DEPTH;

    // ---------------- state ----------------
    scec_pkg::mode_t   mode_reg;
    scec_pkg::len_t    match_len_reg, match_len_next;
    scec_pkg::byte_t   match_reg [HD];          // held entity prefix (payload)

    scec_pkg::byte_t   res_reg [ML];            // pending result bytes, head at 0
    scec_pkg::len_t    res_cnt_reg;
    logic              res_valid_reg;
    logic              res_end_reg;

    // ---------------- handshakes ----------------
    logic in_acc, out_pop, cfg_acc;

    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid & cfg_ready;
    assign out_pop   = m_tvalid & m_tready;
    // free when empty, or when the last pending byte leaves this cycle
    assign s_tready  = ~res_valid_reg | (m_tready & (res_cnt_reg == 3'd1));
    assign in_acc    = s_tvalid & s_tready;

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = res_reg[0];
    assign m_tuser  = (res_cnt_reg == 3'd1);
    assign m_tlast  = (res_cnt_reg == 3'd1) & res_end_reg;

    // ---------------- entity matching ----------------
    scec_pkg::byte_t   in_byte;
    logic              in_end;
    logic              unesc_hit, esc_hit;
    scec_pkg::ent_idx_t unesc_idx, esc_idx;

    assign in_byte = s_tdata;
    assign in_end  = s_tlast;

    // first entity whose text extends the held prefix by the incoming byte,
    // and first entity whose character equals the incoming byte
    always_comb begin
        logic prefix_ok;
        unesc_hit = 1'b0;
        unesc_idx = '0;
        esc_hit   = 1'b0;
        esc_idx   = '0;
        for (int i = 0; i < NE; i++) begin
            prefix_ok = 1'b1;
            for (int k = 0; k < HD; k++) begin
                if ((3'(k) < match_len_reg) &&
                    (scec_pkg::ENT_TEXT[i][k] != match_reg[k])) begin
                    prefix_ok = 1'b0;
                end
            end
            if (!unesc_hit && prefix_ok && (scec_pkg::ENT_LEN[i] > match_len_reg) &&
                (scec_pkg::ENT_TEXT[i][match_len_reg] == in_byte)) begin
                unesc_hit = 1'b1;
                unesc_idx = 4'(i);
            end
            if (!esc_hit && (scec_pkg::ENT_CHAR[i] == in_byte)) begin
                esc_hit = 1'b1;
                esc_idx = 4'(i);
            end
        end
    end

    // ---------------- result list for this byte ----------------
    scec_pkg::byte_t res_next [ML];
    scec_pkg::len_t  res_cnt_next;
    scec_pkg::len_t  n_held;       // held bytes flushed ahead of the extra byte
    scec_pkg::byte_t extra_byte;
    logic            has_extra;
    logic            hold_wr;
    scec_pkg::len_t  hold_pos;

    always_comb begin
        logic fresh;
        fresh          = 1'b0;
        n_held         = '0;
        extra_byte     = in_byte;
        has_extra      = 1'b0;
        hold_wr        = 1'b0;
        hold_pos       = '0;
        match_len_next = match_len_reg;

        if (mode_reg == scec_pkg::MODE_UNESCAPE) begin
            if (match_len_reg == 3'd0) begin
                fresh = 1'b1;
            end else if (unesc_hit) begin
                if (scec_pkg::ENT_LEN[unesc_idx] == match_len_reg + 3'd1) begin
                    // entity complete: replace by its character
                    extra_byte     = scec_pkg::ENT_CHAR[unesc_idx];
                    has_extra      = 1'b1;
                    match_len_next = '0;
                end else if (in_end) begin
                    // text ends inside an entity: give it back unchanged
                    n_held         = match_len_reg;
                    has_extra      = 1'b1;
                    match_len_next = '0;
                end else begin
                    hold_wr        = 1'b1;
                    hold_pos       = match_len_reg;
                    match_len_next = match_len_reg + 3'd1;
                end
            end else begin
                // broken entity: flush, then look at the byte afresh
                n_held         = match_len_reg;
                match_len_next = '0;
                fresh          = 1'b1;
            end
            if (fresh) begin
                if ((in_byte == scec_pkg::CH_AMP) && !in_end) begin
                    hold_wr        = 1'b1;
                    hold_pos       = '0;
                    match_len_next = 3'd1;
                end else begin
                    has_extra = 1'b1;
                end
            end
        end

        if (mode_reg == scec_pkg::MODE_ESCAPE) begin
            if (esc_hit) begin
                for (int k = 0; k < ML; k++) begin
                    res_next[k] = scec_pkg::ENT_TEXT[esc_idx][k];
                end
                res_cnt_next = scec_pkg::ENT_LEN[esc_idx];
            end else begin
                for (int k = 0; k < ML; k++) begin
                    res_next[k] = in_byte;
                end
                res_cnt_next = 3'd1;
            end
        end else begin
            for (int k = 0; k < ML; k++) begin
                if ((k < HD) && (3'(k) < n_held)) begin
                    res_next[k] = match_reg[k < HD ? k : 0];
                end else begin
                    res_next[k] = extra_byte;
                end
            end
            res_cnt_next = n_held + {2'b00, has_extra};
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= scec_pkg::MODE_ESCAPE;
            match_len_reg <= '0;
            res_valid_reg <= 1'b0;
            res_cnt_reg   <= '0;
        end else begin
            if (cfg_acc) begin
                mode_reg      <= scec_pkg::mode_t'(cfg_data);
                match_len_reg <= '0;
            end else if (in_acc) begin
                match_len_reg <= match_len_next;
            end

            if (in_acc) begin
                res_valid_reg <= (res_cnt_next != 3'd0);
                res_cnt_reg   <= res_cnt_next;
            end else if (out_pop) begin
                res_valid_reg <= (res_cnt_reg != 3'd1);
                res_cnt_reg   <= res_cnt_reg - 3'd1;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge aclk) begin
        if (in_acc && hold_wr) begin
            match_reg[hold_pos] <= in_byte;
        end
        if (in_acc) begin
            res_reg     <= res_next;
            res_end_reg <= in_end;
        end else if (out_pop) begin
            for (int k = 0; k < ML - 1; k++) begin
                res_reg[k] <= res_reg[k + 1];
            end
        end
    end

endmodule

[tb/special_char_entity_codec_core_tb.sv]
// Testbench for the special-character entity codec: random and directed text, self-checking.
module special_char_entity_codec_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scec_pkg::*;

    localparam int CYCLE_LIMIT = 200000;  // far above the slowest legal run
    localparam int DRAIN_GAP   = 16;      // settle time once the result queue is empty
    localparam int HOLD_CYCLES = 400;     // long receiver hold-off, fills the result path
    localparam int MAX_REPORTS = 10;

    // One converted byte as seen on the m_ channel.
    typedef struct packed {
        byte_t data;       // out_byte
        logic  run_last;   // last result of its input request
        logic  text_last;  // last result of the whole text
    } out_beat_t;

    // Predicts the converted text and checks the m_ stream against it.
    class codec_scoreboard;
        string     ent_str [NUM_ENT];
        byte_t     ent_chr [NUM_ENT];
        mode_t     mode;
        byte_t     held [HOLD_DEPTH];  // open entity prefix in unescape mode
        int        held_len;
        byte_t     step_out [$];       // bytes caused by the current request
        out_beat_t pending_out [$];    // results still to come, oldest first
        int        errors;

        function new();
            ent_str = '{"&amp;", "&lt;", "&gt;", "&#40;", "&#41;",
                        "&#42;", "&#43;", "&#63;", "&#124;"};
            ent_chr = '{"&", "<", ">", "(", ")", "*", "+", "?", "|"};
            mode     = MODE_ESCAPE;
            held_len = 0;
            errors   = 0;
        endfunction

        // A mode write drops a held partial entity without sending it.
        function void set_mode(mode_t m);
            mode     = m;
            held_len = 0;
        endfunction

        function void flush_held();
            for (int j = 0; j < held_len; j++)
                step_out.push_back(held[j]);
            held_len = 0;
        endfunction

        // Byte seen with nothing held: an ampersand opens a prefix unless the text ends.
        function void start_fresh(byte_t b, logic last);
            if (b == CH_AMP && !last) begin
                held[0]  = b;
                held_len = 1;
            end else begin
                step_out.push_back(b);
            end
        endfunction

        function void take_text_byte(byte_t b, logic last);
            bit        hit;
            bit        same;
            out_beat_t beat;
            step_out.delete();
            if (mode == MODE_ESCAPE) begin
                hit = 0;
                for (int e = 0; e < NUM_ENT; e++) begin
                    if (!hit && ent_chr[e] == b) begin
                        hit = 1;
                        for (int j = 0; j < ent_str[e].len(); j++)
                            step_out.push_back(ent_str[e][j]);
                    end
                end
                if (!hit)
                    step_out.push_back(b);
            end else if (held_len == 0) begin
                start_fresh(b, last);
            end else begin
                hit = 0;
                for (int e = 0; e < NUM_ENT; e++) begin
                    same = (ent_str[e].len() > held_len) && (ent_str[e][held_len] == b);
                    for (int j = 0; j < held_len; j++)
                        if (held[j] != ent_str[e][j])
                            same = 0;
                    if (!hit && same) begin
                        hit = 1;
                        if (ent_str[e].len() == held_len + 1) begin
                            step_out.push_back(ent_chr[e]);
                            held_len = 0;
                        end else if (last) begin
                            // text ends inside an entity: everything goes out as is
                            flush_held();
                            step_out.push_back(b);
                        end else begin
                            held[held_len] = b;
                            held_len++;
                        end
                    end
                end
                if (!hit) begin
                    // broken entity: held bytes go out, the byte is looked at again
                    flush_held();
                    start_fresh(b, last);
                end
            end
            foreach (step_out[k]) begin
                beat.data      = step_out[k];
                beat.run_last  = (k == step_out.size() - 1);
                beat.text_last = beat.run_last && last;
                pending_out.push_back(beat);
            end
        endfunction

        function void check_out_byte(byte_t d, logic rl, logic tl);
            out_beat_t want;
            if (pending_out.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result %02h run_last %0b text_last %0b",
                             $time, d, rl, tl);
                return;
            end
            want = pending_out.pop_front();
            if (want.data !== d || want.run_last !== rl || want.text_last !== tl) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: mismatch, expected %02h/%0b/%0b, got %02h/%0b/%0b",
                             $time, want.data, want.run_last, want.text_last, d, rl, tl);
            end
        endfunction

        function void close_out();
            if (pending_out.size() != 0) begin
                errors += pending_out.size();
                $display("%0d expected results never arrived", pending_out.size());
            end
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_data;

    codec_scoreboard sb;

    bit tx_steady;   // sender offers a request every cycle
    bit rx_steady;   // receiver always ready
    bit hold_req;    // kicks off the long receiver hold-off
    bit hold_off;
    int cycles = 0;

    special_char_entity_codec_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: random back-pressure unless held off or steady, set at the falling edge.
    always @(negedge aclk) begin
        if (hold_off)
            m_tready = 1'b0;
        else if (rx_steady)
            m_tready = 1'b1;
        else
            m_tready = ($urandom_range(99) >= 27);
    end

    // Long hold-off, counted here so the sender keeps pushing into a full block.
    initial begin
        hold_off = 1'b0;
        wait (hold_req);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off = 1'b0;
    end

    // Result monitor: every accepted result byte is checked in order.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_out_byte(m_tdata, m_tuser, m_tlast);
    end

    // One input request; valid stays up afterwards so back-to-back requests need no gap.
    task automatic send_byte(byte_t b, bit last);
        @(negedge aclk);
        while (!tx_steady && $urandom_range(99) < 27) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = last;
        forever begin
            @(posedge aclk);
            if (s_tready)
                break;
        end
        sb.take_text_byte(b, last);
    endtask

    task automatic send_text(string txt, bit end_text);
        for (int i = 0; i < txt.len(); i++)
            send_byte(txt[i], end_text && (i == txt.len() - 1));
    endtask

    // Sender pauses until every predicted result is out, then lets the block settle
    // (a held prefix gives no result, so the queue can empty early).
    task automatic wait_drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.pending_out.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_GAP) @(posedge aclk);
    endtask

    // Mode register write; only issued with the block idle.
    task automatic write_mode(mode_t m);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = m;
        forever begin
            @(posedge aclk);
            if (cfg_ready)
                break;
        end
        sb.set_mode(m);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Random text. Unescape phases mix whole entities, broken prefixes,
    // stray ampersands and hash signs, and random bytes.
    task automatic run_random(int n_items, mode_t m);
        byte_t chunk [$];
        int    sent;
        int    sel;
        int    e;
        int    cut;
        sent = 0;
        while (sent < n_items) begin
            chunk.delete();
            sel = $urandom_range(99);
            if (m == MODE_ESCAPE) begin
                if (sel < 30)
                    chunk.push_back(sb.ent_chr[$urandom_range(NUM_ENT - 1)]);
                else
                    chunk.push_back(byte_t'($urandom_range(255)));
            end else if (sel < 60) begin
                e   = $urandom_range(NUM_ENT - 1);
                cut = sb.ent_str[e].len();
                if (sel >= 45)
                    cut = $urandom_range(cut - 1, 1);
                for (int k = 0; k < cut; k++)
                    chunk.push_back(sb.ent_str[e][k]);
                if (sel >= 45)
                    chunk.push_back(byte_t'($urandom_range(255)));
            end else if (sel < 70) begin
                chunk.push_back((sel < 66) ? CH_AMP : byte_t'("#"));
            end else begin
                chunk.push_back(byte_t'($urandom_range(255)));
            end
            foreach (chunk[i])
                send_byte(chunk[i], $urandom_range(11) == 0);
            sent += chunk.size();
            if ($urandom_range(39) == 0)
                wait_drain();
        end
    endtask

    initial begin
        sb        = new();
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        hold_req  = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed escape: all nine specials, then the top byte value ending the text.
        write_mode(MODE_ESCAPE);
        for (int e = 0; e < NUM_ENT; e++)
            send_byte(sb.ent_chr[e], 1'b0);
        send_byte(8'hff, 1'b1);
        wait_drain();

        // Directed unescape: longest entity, broken prefix, ampersand restarting
        // a prefix, text ending inside an entity and on a lone ampersand.
        write_mode(MODE_UNESCAPE);
        send_text("&#124;", 1'b0);
        send_text("&q", 1'b0);
        send_text("&&gt;", 1'b0);
        send_text("&#4", 1'b1);
        send_text("&", 1'b1);
        wait_drain();

        // Random phases across both modes; each mode change may drop a held prefix.
        run_random(70, MODE_UNESCAPE);
        wait_drain();
        write_mode(MODE_ESCAPE);
        run_random(70, MODE_ESCAPE);
        wait_drain();

        // Receiver stalls for a long stretch while the sender keeps requesting.
        write_mode(MODE_UNESCAPE);
        tx_steady = 1'b1;
        hold_req  = 1'b1;
        run_random(70, MODE_UNESCAPE);
        wait_drain();

        // Same mode written again, no idling on either side.
        write_mode(MODE_UNESCAPE);
        rx_steady = 1'b1;
        run_random(70, MODE_UNESCAPE);
        wait_drain();
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        write_mode(MODE_ESCAPE);
        run_random(70, MODE_ESCAPE);
        wait_drain();
        write_mode(MODE_UNESCAPE);
        run_random(70, MODE_UNESCAPE);
        wait_drain();

        sb.close_out();
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
rtl/scec_pkg.sv
rtl/special_char_entity_codec_core.sv
tb/special_char_entity_codec_core_tb.sv
